// ===== design/mss_pkg.sv =====
// Shared types and constants for the motor safety supervisor.
package mss_pkg;

  localparam int unsigned ACTION_W  = 4;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned STEP_W    = 9;
  localparam int unsigned RATE_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;

  // Reset values of state and configuration
  localparam int unsigned TRIP_TEMP_RST  = 800;
  localparam int unsigned CLEAR_TEMP_RST = 600;
  localparam int unsigned STEP_RST       = 100;
  localparam int unsigned CEIL_RST       = 2000;
  localparam int unsigned FLOOR_RST      = 500;
  localparam int unsigned RAMP_UP_RST    = 25;
  localparam int unsigned RAMP_DOWN_RST  = 30;
  localparam int unsigned TARGET_RST     = 1500;
  localparam int unsigned LAST_TEMP_RST  = 250;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE     = 3'd0,
    MODE_ARMED    = 3'd1,
    MODE_RUNNING  = 3'd2,
    MODE_FAULT    = 3'd3,
    MODE_SHUTDOWN = 3'd4
  } mode_e;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK     = 4'd0,
    ACT_ARM      = 4'd1,
    ACT_DISARM   = 4'd2,
    ACT_START    = 4'd3,
    ACT_ESTOP    = 4'd4,
    ACT_RELEASE  = 4'd5,
    ACT_RESET    = 4'd6,
    ACT_UP       = 4'd7,
    ACT_DOWN     = 4'd8,
    ACT_SHUTDOWN = 4'd9
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIP_TEMP   = 3'd0,
    CFG_CLEAR_TEMP  = 3'd1,
    CFG_SPEED_STEP  = 3'd2,
    CFG_SPEED_CEIL  = 3'd3,
    CFG_SPEED_FLOOR = 3'd4,
    CFG_RAMP_UP     = 3'd5,
    CFG_RAMP_DOWN   = 3'd6
  } cfg_reg_e;

endpackage

// ===== design/mss_if.sv =====
// Command and response stream interfaces of the motor safety supervisor.
interface mss_cmd_if #(
  parameter int unsigned TEMP_WIDTH = 11
);
  logic                          valid;
  logic                          ready;
  logic [mss_pkg::ACTION_W-1:0]  action;
  logic [TEMP_WIDTH-1:0]         temperature;

  modport source (output valid, action, temperature, input ready);
  modport sink   (input valid, action, temperature, output ready);
endinterface

interface mss_rsp_if #(
  parameter int unsigned SPEED_WIDTH = 12
);
  logic                        valid;
  logic                        ready;
  logic [mss_pkg::MODE_W-1:0]  mode;
  logic                        command_ok;
  logic                        estop_latched;
  logic [SPEED_WIDTH-1:0]      target_speed;
  logic [SPEED_WIDTH-1:0]      motor_speed;
  logic                        overheat_trip;

  modport source (output valid, mode, command_ok, estop_latched, target_speed, motor_speed,
                  overheat_trip, input ready);
  modport sink   (input valid, mode, command_ok, estop_latched, target_speed, motor_speed,
                  overheat_trip, output ready);
endinterface

// ===== design/mss_cfg_regs.sv =====
// Configuration register file: limits, speed step and ramp rates.
module mss_cfg_regs #(
  parameter int unsigned SPEED_WIDTH = 12,
  parameter int unsigned TEMP_WIDTH  = 11,
  parameter int unsigned CFG_WIDTH   = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mss_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_WIDTH-1:0]            cfg_data_i,
  output logic [TEMP_WIDTH-1:0]           trip_temp_o,
  output logic [TEMP_WIDTH-1:0]           clear_temp_o,
  output logic [mss_pkg::STEP_W-1:0]      speed_step_o,
  output logic [SPEED_WIDTH-1:0]          speed_ceil_o,
  output logic [SPEED_WIDTH-1:0]          speed_floor_o,
  output logic [mss_pkg::RATE_W-1:0]      ramp_up_o,
  output logic [mss_pkg::RATE_W-1:0]      ramp_down_o
);
  import mss_pkg::*;

  logic [TEMP_WIDTH-1:0]  trip_temp_q, clear_temp_q;
  logic [STEP_W-1:0]      speed_step_q;
  logic [SPEED_WIDTH-1:0] speed_ceil_q, speed_floor_q;
  logic [RATE_W-1:0]      ramp_up_q, ramp_down_q;

  // Decode the register index and take the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trip_temp_q   <= TEMP_WIDTH'(TRIP_TEMP_RST);
      clear_temp_q  <= TEMP_WIDTH'(CLEAR_TEMP_RST);
      speed_step_q  <= STEP_W'(STEP_RST);
      speed_ceil_q  <= SPEED_WIDTH'(CEIL_RST);
      speed_floor_q <= SPEED_WIDTH'(FLOOR_RST);
      ramp_up_q     <= RATE_W'(RAMP_UP_RST);
      ramp_down_q   <= RATE_W'(RAMP_DOWN_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_TRIP_TEMP:   trip_temp_q   <= cfg_data_i[TEMP_WIDTH-1:0];
        CFG_CLEAR_TEMP:  clear_temp_q  <= cfg_data_i[TEMP_WIDTH-1:0];
        CFG_SPEED_STEP:  speed_step_q  <= cfg_data_i[STEP_W-1:0];
        CFG_SPEED_CEIL:  speed_ceil_q  <= cfg_data_i[SPEED_WIDTH-1:0];
        CFG_SPEED_FLOOR: speed_floor_q <= cfg_data_i[SPEED_WIDTH-1:0];
        CFG_RAMP_UP:     ramp_up_q     <= cfg_data_i[RATE_W-1:0];
        CFG_RAMP_DOWN:   ramp_down_q   <= cfg_data_i[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  assign trip_temp_o   = trip_temp_q;
  assign clear_temp_o  = clear_temp_q;
  assign speed_step_o  = speed_step_q;
  assign speed_ceil_o  = speed_ceil_q;
  assign speed_floor_o = speed_floor_q;
  assign ramp_up_o     = ramp_up_q;
  assign ramp_down_o   = ramp_down_q;

endmodule

// ===== design/mss_core.sv =====
// Supervisor core: input register, mode and speed state, next-state logic, result register.
module mss_core #(
  parameter int unsigned SPEED_WIDTH = 12,
  parameter int unsigned TEMP_WIDTH  = 11
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  mss_cmd_if.sink                     cmd_i,
  mss_rsp_if.source                   rsp_o,
  input  logic [TEMP_WIDTH-1:0]       trip_temp_i,
  input  logic [TEMP_WIDTH-1:0]       clear_temp_i,
  input  logic [mss_pkg::STEP_W-1:0]  speed_step_i,
  input  logic [SPEED_WIDTH-1:0]      speed_ceil_i,
  input  logic [SPEED_WIDTH-1:0]      speed_floor_i,
  input  logic [mss_pkg::RATE_W-1:0]  ramp_up_i,
  input  logic [mss_pkg::RATE_W-1:0]  ramp_down_i
);
  import mss_pkg::*;

  localparam int unsigned SumWidth = SPEED_WIDTH + 1;
  localparam int unsigned DiffWidth = (SPEED_WIDTH > STEP_W) ? SPEED_WIDTH : STEP_W;
  localparam int unsigned TgtWidth = DiffWidth + 1;

  // Input register
  logic                  s1_valid_q;
  logic [ACTION_W-1:0]   s1_action_q;
  logic [TEMP_WIDTH-1:0] s1_temp_q;

  // Supervisor state
  mode_e                  mode_q, mode_d;
  logic                   estop_q, estop_d;
  logic [SPEED_WIDTH-1:0] target_q, target_d;
  logic [SPEED_WIDTH-1:0] speed_q, speed_d;
  logic [TEMP_WIDTH-1:0]  last_temp_q, last_temp_d;
  logic                   ok_d, trip_d;

  // Result register
  logic                   out_valid_q;
  mode_e                  out_mode_q;
  logic                   out_ok_q, out_estop_q, out_trip_q;
  logic [SPEED_WIDTH-1:0] out_target_q, out_speed_q;

  logic out_free, s1_fire, cmd_fire;

  // Ramp and target arithmetic
  logic [SPEED_WIDTH:0]   ramp_up_sum;
  logic [SPEED_WIDTH-1:0] ramp_dn_diff;
  logic                   ramp_dn_under;
  logic [SPEED_WIDTH-1:0] ramp_speed;
  logic [TgtWidth-1:0]    tgt_up_sum;
  logic [SPEED_WIDTH-1:0] tgt_up;
  logic [DiffWidth-1:0]   tgt_dn_diff;
  logic                   tgt_dn_under;
  logic [SPEED_WIDTH-1:0] tgt_dn;

  // Handshake: the result register frees up when empty or being drained
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign s1_fire     = s1_valid_q && out_free;
  assign cmd_i.ready = !s1_valid_q || out_free;
  assign cmd_fire    = cmd_i.valid && cmd_i.ready;

  // Move motor speed toward target without passing it
  assign ramp_up_sum   = {1'b0, speed_q} + SumWidth'(ramp_up_i);
  assign ramp_dn_under = speed_q < SPEED_WIDTH'(ramp_down_i);
  assign ramp_dn_diff  = speed_q - SPEED_WIDTH'(ramp_down_i);

  always_comb begin
    if (speed_q < target_q) begin
      ramp_speed = (ramp_up_sum > SumWidth'(target_q)) ? target_q
                                                       : ramp_up_sum[SPEED_WIDTH-1:0];
    end else if (speed_q > target_q) begin
      ramp_speed = (ramp_dn_under || ramp_dn_diff < target_q) ? target_q : ramp_dn_diff;
    end else begin
      ramp_speed = speed_q;
    end
  end

  // Step target up to the ceiling or down to the floor
  assign tgt_up_sum   = TgtWidth'(target_q) + TgtWidth'(speed_step_i);
  assign tgt_up       = (tgt_up_sum > TgtWidth'(speed_ceil_i)) ? speed_ceil_i
                                                               : tgt_up_sum[SPEED_WIDTH-1:0];
  assign tgt_dn_under = DiffWidth'(target_q) < DiffWidth'(speed_step_i);
  assign tgt_dn_diff  = DiffWidth'(target_q) - DiffWidth'(speed_step_i);
  assign tgt_dn       = (tgt_dn_under || tgt_dn_diff < DiffWidth'(speed_floor_i))
                        ? speed_floor_i : tgt_dn_diff[SPEED_WIDTH-1:0];

  // Next state for the item in the input register
  always_comb begin
    mode_d      = mode_q;
    estop_d     = estop_q;
    target_d    = target_q;
    speed_d     = speed_q;
    last_temp_d = last_temp_q;
    ok_d        = 1'b0;
    trip_d      = 1'b0;
    if (mode_q == MODE_SHUTDOWN) begin
      ok_d = (action_e'(s1_action_q) == ACT_TICK);
    end else begin
      unique case (action_e'(s1_action_q))
        ACT_TICK: begin
          ok_d        = 1'b1;
          last_temp_d = s1_temp_q;
          if (mode_q == MODE_RUNNING) begin
            speed_d = ramp_speed;
          end else begin
            speed_d  = '0;
            target_d = '0;
          end
          if (s1_temp_q > trip_temp_i && mode_q != MODE_FAULT) begin
            estop_d = 1'b1;
            mode_d  = MODE_FAULT;
            trip_d  = 1'b1;
          end
        end
        ACT_ARM: begin
          if (mode_q == MODE_IDLE) begin
            mode_d = MODE_ARMED;
            ok_d   = 1'b1;
          end
        end
        ACT_DISARM: begin
          if (mode_q == MODE_ARMED || mode_q == MODE_RUNNING) begin
            mode_d = MODE_IDLE;
            ok_d   = 1'b1;
          end
        end
        ACT_START: begin
          if (mode_q == MODE_ARMED) begin
            mode_d = MODE_RUNNING;
            ok_d   = 1'b1;
          end
        end
        ACT_ESTOP: begin
          estop_d = 1'b1;
          mode_d  = MODE_FAULT;
          ok_d    = 1'b1;
        end
        ACT_RELEASE: begin
          if (estop_q) begin
            estop_d = 1'b0;
            ok_d    = 1'b1;
          end
        end
        ACT_RESET: begin
          if (mode_q == MODE_FAULT && !estop_q && last_temp_q <= clear_temp_i) begin
            mode_d = MODE_IDLE;
            ok_d   = 1'b1;
          end
        end
        ACT_UP: begin
          if (mode_q == MODE_RUNNING) begin
            target_d = tgt_up;
            ok_d     = 1'b1;
          end
        end
        ACT_DOWN: begin
          if (mode_q == MODE_RUNNING) begin
            target_d = tgt_dn;
            ok_d     = 1'b1;
          end
        end
        ACT_SHUTDOWN: begin
          mode_d = MODE_SHUTDOWN;
          ok_d   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (cmd_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Capture the command payload on transfer
  always_ff @(posedge clk_i) begin
    if (cmd_fire) begin
      s1_action_q <= cmd_i.action;
      s1_temp_q   <= cmd_i.temperature;
    end
  end

  // Commit state as the item moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      estop_q     <= 1'b0;
      target_q    <= SPEED_WIDTH'(TARGET_RST);
      speed_q     <= '0;
      last_temp_q <= TEMP_WIDTH'(LAST_TEMP_RST);
    end else if (s1_fire) begin
      mode_q      <= mode_d;
      estop_q     <= estop_d;
      target_q    <= target_d;
      speed_q     <= speed_d;
      last_temp_q <= last_temp_d;
    end
  end

  // Result register valid: hold until the response transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_mode_q   <= mode_d;
      out_ok_q     <= ok_d;
      out_estop_q  <= estop_d;
      out_target_q <= target_d;
      out_speed_q  <= speed_d;
      out_trip_q   <= trip_d;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.mode          = out_mode_q;
  assign rsp_o.command_ok    = out_ok_q;
  assign rsp_o.estop_latched = out_estop_q;
  assign rsp_o.target_speed  = out_target_q;
  assign rsp_o.motor_speed   = out_speed_q;
  assign rsp_o.overheat_trip = out_trip_q;

endmodule

// ===== design/motor_safety_supervisor_unit.sv =====
// Path: a transferred command passes the input register, then the result register, before its response is valid.
// Throughput: one item per cycle while the response side is ready; an input register and a result register
// bound the single pass, and supervisor state commits as an item leaves the input register.
// Reset (async, active low): mode idle, e-stop clear, target 1500, motor speed 0,
// last temperature 250, configuration registers at their default limits and rates.
module motor_safety_supervisor_unit #(
  parameter int unsigned SPEED_WIDTH = 12,
  parameter int unsigned TEMP_WIDTH  = 11,
  localparam int unsigned CfgWidth   =
    (SPEED_WIDTH > TEMP_WIDTH)
      ? ((SPEED_WIDTH > mss_pkg::STEP_W) ? SPEED_WIDTH : mss_pkg::STEP_W)
      : ((TEMP_WIDTH > mss_pkg::STEP_W) ? TEMP_WIDTH : mss_pkg::STEP_W)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CfgWidth-1:0]            cfg_data_i,
  mss_cmd_if.sink                        cmd_i,
  mss_rsp_if.source                      rsp_o
);
  import mss_pkg::*;

  logic [TEMP_WIDTH-1:0]  trip_temp, clear_temp;
  logic [STEP_W-1:0]      speed_step;
  logic [SPEED_WIDTH-1:0] speed_ceil, speed_floor;
  logic [RATE_W-1:0]      ramp_up, ramp_down;

  // Configuration registers
  mss_cfg_regs #(
    .SPEED_WIDTH (SPEED_WIDTH),
    .TEMP_WIDTH  (TEMP_WIDTH),
    .CFG_WIDTH   (CfgWidth)
  ) u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .trip_temp_o   (trip_temp),
    .clear_temp_o  (clear_temp),
    .speed_step_o  (speed_step),
    .speed_ceil_o  (speed_ceil),
    .speed_floor_o (speed_floor),
    .ramp_up_o     (ramp_up),
    .ramp_down_o   (ramp_down)
  );

  // Supervisor pipeline
  mss_core #(
    .SPEED_WIDTH (SPEED_WIDTH),
    .TEMP_WIDTH  (TEMP_WIDTH)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_i),
    .rsp_o         (rsp_o),
    .trip_temp_i   (trip_temp),
    .clear_temp_i  (clear_temp),
    .speed_step_i  (speed_step),
    .speed_ceil_i  (speed_ceil),
    .speed_floor_i (speed_floor),
    .ramp_up_i     (ramp_up),
    .ramp_down_i   (ramp_down)
  );

`ifndef SYNTHESIS
  // An overtemperature trip always lands in fault with the e-stop latched
  a_trip_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.overheat_trip |->
      rsp_o.mode == MODE_FAULT && rsp_o.estop_latched)
    else $error("overheat trip without fault and latched e-stop");

  // Only ticks trip, and ticks are always accepted
  a_trip_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.overheat_trip |-> rsp_o.command_ok)
    else $error("overheat trip on a refused item");

  // A transferred command reaches the result register by way of the input register when drained
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready) ##1 rsp_o.ready |=> rsp_o.valid)
    else $error("response missing after command transfer");
`endif

endmodule
